// ----- design/rir_pkg.sv -----
// shared constants for the rounded integer square root block
package rir_pkg;

   localparam int DEFAULT_DATA_WIDTH = 32;
   localparam int ROOT_WIDTH         = 16;

   // one root digit per pipeline stage, enough digits for the positive range
   function automatic int digit_count(input int data_width);
      return (data_width + 1) / 2;
   endfunction

endpackage

// ----- design/rir_digit.sv -----
// one digit stage of the shift-and-subtract square root pipeline
module rir_digit import rir_pkg::*; #(
   parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
   parameter int NDIG       = digit_count(DEFAULT_DATA_WIDTH),
   parameter int SHIFT_BITS = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [DATA_WIDTH-1:0] in_rem,
   input  logic [NDIG-1:0]       in_q,
   output logic                  out_valid,
   output logic [DATA_WIDTH-1:0] out_rem,
   output logic [NDIG-1:0]       out_q
);

   localparam int EW = 2 * NDIG + 2;

   logic [EW-1:0]         trial;
   logic [EW-1:0]         rem_ext;
   logic                  take;
   logic                  valid_ff;
   logic                  valid_in;
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] rem_in;
   logic [NDIG-1:0]       q_ff;
   logic [NDIG-1:0]       q_in;

   // trial subtrahend is (4q + 1) at this digit's weight
   always_comb begin
      trial   = EW'({in_q, 2'b01}) << SHIFT_BITS;
      rem_ext = EW'(in_rem);
      take    = (rem_ext >= trial);
      rem_in  = take ? DATA_WIDTH'(rem_ext - trial) : in_rem;
      q_in    = {in_q[NDIG-2:0], take};
      valid_in = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_q     = q_ff;

endmodule

// ----- design/rir_out.sv -----
// rounding step, output register and skid register
module rir_out import rir_pkg::*; #(
   parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
   parameter int NDIG       = digit_count(DEFAULT_DATA_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [DATA_WIDTH-1:0] in_rem,
   input  logic [NDIG-1:0]       in_q,
   output logic                  up_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ROOT_WIDTH-1:0] rsp_root
);

   logic [NDIG:0]           rounded;
   logic [ROOT_WIDTH-1:0]   root_new;
   logic                    take_out;
   logic                    incoming;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic [ROOT_WIDTH-1:0]   out_root_ff;
   logic [ROOT_WIDTH-1:0]   out_root_in;
   logic                    skid_valid_ff;
   logic                    skid_valid_in;
   logic [ROOT_WIDTH-1:0]   skid_root_ff;
   logic [ROOT_WIDTH-1:0]   skid_root_in;

   // remainder is value - q^2; round up when it exceeds q
   always_comb begin
      rounded  = {1'b0, in_q} + (NDIG+1)'(in_rem > DATA_WIDTH'(in_q));
      root_new = ROOT_WIDTH'(rounded);
   end

   always_comb begin
      take_out      = !out_valid_ff || !rsp_stall;
      incoming      = in_valid && !skid_valid_ff;
      out_valid_in  = out_valid_ff;
      out_root_in   = out_root_ff;
      skid_valid_in = skid_valid_ff;
      skid_root_in  = skid_root_ff;
      if (take_out) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_root_in   = skid_root_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = incoming;
            out_root_in  = root_new;
         end
      end else if (incoming) begin
         // output held, park the transaction in the skid register
         skid_valid_in = 1'b1;
         skid_root_in  = root_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_root_ff  <= out_root_in;
      skid_root_ff <= skid_root_in;
   end

   assign up_stall  = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_root  = out_root_ff;

endmodule

// ----- design/rounded_integer_square_root.sv -----
// Rounded integer square root, one digit per pipeline stage.
// A transaction passes through the digit stages and then the output register to rsp_root.
// Throughput: one transaction per cycle while req_stall is low; req_stall rises only
//   when the skid register holds a result behind a stalled output.
// Reset (synchronous) clears all valid bits; payload registers are not reset.
module rounded_integer_square_root import rir_pkg::*; #(
   parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ROOT_WIDTH-1:0]        rsp_root
);

   localparam int NDIG = digit_count(DATA_WIDTH);

   logic                  advance;
   logic                  valid_stage [0:NDIG];
   logic [DATA_WIDTH-1:0] rem_stage   [0:NDIG];
   logic [NDIG-1:0]       q_stage     [0:NDIG];

   assign advance = !req_stall;

   // zero and negative operands enter with a zero remainder
   assign valid_stage[0] = req_valid;
   assign rem_stage[0]   = req_value[DATA_WIDTH-1] ? '0 : DATA_WIDTH'($unsigned(req_value));
   assign q_stage[0]     = '0;

   for (genvar k = 0; k < NDIG; k++) begin : g_digit
      rir_digit #(
         .DATA_WIDTH (DATA_WIDTH),
         .NDIG       (NDIG),
         .SHIFT_BITS (2 * (NDIG - 1 - k))
      ) u_digit (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid_stage[k]),
         .in_rem    (rem_stage[k]),
         .in_q      (q_stage[k]),
         .out_valid (valid_stage[k+1]),
         .out_rem   (rem_stage[k+1]),
         .out_q     (q_stage[k+1])
      );
   end

   rir_out #(
      .DATA_WIDTH (DATA_WIDTH),
      .NDIG       (NDIG)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_stage[NDIG]),
      .in_rem    (rem_stage[NDIG]),
      .in_q      (q_stage[NDIG]),
      .up_stall  (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_root  (rsp_root)
   );

endmodule

// ----- design/rir_checker.sv -----
// port-level checks for the rounded integer square root, bound to the top level
module rir_checker import rir_pkg::*; #(
   parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic signed [DATA_WIDTH-1:0] req_value,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [ROOT_WIDTH-1:0]        rsp_root
);

   localparam int CAPACITY = digit_count(DATA_WIDTH) + 2;
   localparam int CW       = $clog2(CAPACITY + 2) + 1;

   logic          acc_in;
   logic          acc_out;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   assign acc_in     = req_valid && !req_stall;
   assign acc_out    = rsp_valid && !rsp_stall;
   assign count_in   = count_ff + CW'(acc_in) - CW'(acc_out);

   // transactions in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != '0)
      else $error("result shown with no transaction in flight");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("more transactions in flight than pipeline holds");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_stall) && $past(rsp_valid))
      else $error("input stalled without a stalled result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_root))
      else $error("stalled result changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_value))
      else $error("stalled request changed");

endmodule

bind rounded_integer_square_root rir_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rir_checker (.*);

// ----- tb/sv/rounded_integer_square_root_checker.sv -----
// checker that predicts and compares rounded square root results
`timescale 1ns / 1ps

module rounded_integer_square_root_checker import rir_pkg::*; #(
   parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [ROOT_WIDTH-1:0]        rsp_root,
   output int                           mismatches,
   output int                           roots_pending
);

   logic [ROOT_WIDTH-1:0] roots_due [$];

   // shift-and-subtract root over powers of four, then round half up
   function automatic logic [ROOT_WIDTH-1:0] expected_root(
      input logic signed [DATA_WIDTH-1:0] value
   );
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] probe;
      if (value <= 0) begin
         return '0;
      end
      rest = '0;
      rest[DATA_WIDTH-1:0] = value;
      root = '0;
      probe = 64'h4000_0000_0000_0000;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      // remainder above the root means value lies past the midpoint of the squares
      if (rest > root) begin
         root = root + 1;
      end
      return root[ROOT_WIDTH-1:0];
   endfunction

   always @(posedge clock) begin
      logic [ROOT_WIDTH-1:0] want;
      if (reset) begin
         roots_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            roots_due.push_back(expected_root(req_value));
         end
         if (rsp_valid && !rsp_stall) begin
            if (roots_due.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual root %0d",
                        $time, rsp_root);
               mismatches++;
            end else begin
               want = roots_due.pop_front();
               if (rsp_root !== want) begin
                  $display("%0t: root mismatch, expected %0d, actual %0d",
                           $time, want, rsp_root);
                  mismatches++;
               end
            end
         end
      end
      roots_pending <= roots_due.size();
   end

endmodule

// ----- tb/sv/rounded_integer_square_root_tb.sv -----
// testbench top: operand stimulus, result back-pressure and verdict
`timescale 1ns / 1ps

module rounded_integer_square_root_tb;
   import rir_pkg::*;

   localparam int DATA_WIDTH   = DEFAULT_DATA_WIDTH;
   localparam int RANDOM_ITEMS = 750;
   localparam int HOLD_AT      = 250;
   localparam int HOLD_CYCLES  = 150;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 40;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic signed [DATA_WIDTH-1:0] req_value;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [ROOT_WIDTH-1:0]        rsp_root;

   int mismatches;
   int roots_pending;
   int issued = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   bit held_off = 1'b0;

   always #5 clock = ~clock;

   rounded_integer_square_root #(.DATA_WIDTH(DATA_WIDTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_root(rsp_root)
   );

   rounded_integer_square_root_checker #(.DATA_WIDTH(DATA_WIDTH)) root_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_root(rsp_root),
      .mismatches(mismatches),
      .roots_pending(roots_pending)
   );

   function automatic logic signed [31:0] random_operand();
      longint n;
      longint sum;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom | 32'h8000_0000;
         2: return $urandom_range(0, 1000);
         3: begin
            // land on and around the rounding points between squares
            n = $urandom_range(0, 46340);
            case ($urandom_range(0, 4))
               0: sum = n * n;
               1: sum = n * n - 1;
               2: sum = n * n + n;
               3: sum = n * n + n + 1;
               default: sum = n * n + $urandom_range(0, 2 * n);
            endcase
            if (sum > 64'sd2147483647) begin
               sum = 64'sd2147483647;
            end
            if (sum < 0) begin
               sum = 0;
            end
            return sum[31:0];
         end
         4: return $urandom >> $urandom_range(1, 31);
         default: return $urandom & 32'h7FFF_FFFF;
      endcase
   endfunction

   task automatic send_operand(input logic signed [DATA_WIDTH-1:0] value);
      int gap;
      int r;
      if (issued >= HOLD_AT && issued < HOLD_AT + 80) begin
         gap = 0;
      end else if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if ($urandom_range(0, 9) == 0) begin
         burst_left = $urandom_range(15, 50);
         gap = 0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            gap = 0;
         end else if (r < 92) begin
            gap = $urandom_range(1, 3);
         end else begin
            gap = $urandom_range(8, 40);
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      issued++;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_operand(0);
      send_operand(1);
      send_operand(2);
      send_operand(3);
      send_operand(4);
      send_operand(5);
      send_operand(6);
      send_operand(7);
      send_operand(8);
      send_operand(9);
      send_operand(12);
      send_operand(13);
      send_operand(-1);
      send_operand(32'h8000_0000);
      send_operand(32'h7FFF_FFFF);
      send_operand(2147395600);
      send_operand(2147395599);
      send_operand(2147441940);
      send_operand(2147441941);
      send_operand(32'h4000_0000);
      send_operand(32'h5555_5555);
      send_operand(32'hAAAA_AAAA);
      send_operand(32'h0000_FFFF);

      repeat (RANDOM_ITEMS) send_operand(random_operand());
      req_valid <= 1'b0;

      do @(posedge clock); while (roots_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // result side back-pressure, with one long hold-off to fill the pipeline
   initial begin
      int n;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held_off && issued >= HOLD_AT) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            case ($urandom_range(0, 5))
               0, 1: begin
                  rsp_stall <= 1'b0;
                  repeat ($urandom_range(10, 60)) @(posedge clock);
               end
               2, 3, 4: begin
                  n = $urandom_range(1, 3);
                  rsp_stall <= 1'b1;
                  repeat (n) @(posedge clock);
                  rsp_stall <= 1'b0;
                  repeat ($urandom_range(1, 4)) @(posedge clock);
               end
               default: begin
                  n = $urandom_range(8, 40);
                  rsp_stall <= 1'b1;
                  repeat (n) @(posedge clock);
                  rsp_stall <= 1'b0;
                  repeat ($urandom_range(1, 4)) @(posedge clock);
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule

// ----- filelist.f -----
design/rir_pkg.sv
design/rir_digit.sv
design/rir_out.sv
design/rounded_integer_square_root.sv
design/rir_checker.sv
tb/sv/rounded_integer_square_root_checker.sv
tb/sv/rounded_integer_square_root_tb.sv
